// File: rtl/sfd_pkg.sv
// Shared types and constants of the SBUS frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

  // Default number of SBUS payload bytes between inner head and inner tail
  localparam int SBUS_PAYLOAD_BYTES_DEF = 23;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OUTER_HEAD = 2'd0;
  localparam logic [1:0] REG_OUTER_TAIL = 2'd1;
  localparam logic [1:0] REG_INNER_HEAD = 2'd2;
  localparam logic [1:0] REG_INNER_TAIL = 2'd3;

  // Reset values of the framing bytes
  localparam logic [7:0] OUTER_HEAD_RST = 8'h48;  // 'H'
  localparam logic [7:0] OUTER_TAIL_RST = 8'h54;  // 'T'
  localparam logic [7:0] INNER_HEAD_RST = 8'h0F;
  localparam logic [7:0] INNER_TAIL_RST = 8'h00;

  // Destination codes of an emitted byte
  localparam logic DEST_SBUS = 1'b0;
  localparam logic DEST_PASS = 1'b1;

  // Parser / sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OUTER_HEAD,
    ST_INNER_HEAD,
    ST_PAYLOAD,
    ST_INNER_TAIL,
    ST_EMIT
  } ctrl_state_t;

  // Framing bytes as programmed
  typedef struct packed {
    logic [7:0] outer_head;
    logic [7:0] outer_tail;
    logic [7:0] inner_head;
    logic [7:0] inner_tail;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;          // store the accepted byte
    logic start_ok;    // begin SBUS run (bytes 1 .. payload+2)
    logic start_fail;  // begin pass-through run (all stored bytes)
    logic emit;        // move one stored byte into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic match_outer_head;
    logic match_outer_tail;
    logic match_inner_head;
    logic match_inner_tail;
    logic payload_done;  // this byte completes the payload
    logic out_free;      // output register can take a beat
    logic emit_last;     // next emitted byte ends the run
  } dp_status_t;

endpackage

// File: rtl/wrapped_sbus_frame_demux_core.sv
// Top level of the SBUS frame deframer: register port, parser and datapath.
`timescale 1ns / 1ps

// Radio bytes arrive one beat at a time and are stored in a frame buffer of
// PAYLOAD_BYTES + 4 entries. A good frame (outer head, inner head,
// PAYLOAD_BYTES payload bytes, inner tail, outer tail) is sent out as its
// PAYLOAD_BYTES + 2 inner bytes with destination 0; on the first mismatch
// every byte stored so far, the failing one included, goes out with
// destination 1, and the parser restarts in idle. last_of_run marks the
// final beat of each run. A byte that does not end a run is accepted
// without a stall. After a byte that ends a run, in_stall stays high
// while the run is emitted (PAYLOAD_BYTES + 2 bytes for a good frame, 1
// to PAYLOAD_BYTES + 4 for a rejected one), as the frame buffer is read
// one entry per cycle, while out_stall allows, into the output register.
// The framing bytes are registers 0 to 3 at byte addresses 0, 4, 8 and
// 12 and reset to 'H', 'T', 0x0F and 0x00.
module wrapped_sbus_frame_demux_core
  import sfd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = SBUS_PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_destination,
  output logic        out_last_of_run,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t st;

  sfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sfd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  sfd_dp #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_byte         (in_rx_byte),
    .cfg             (cfg),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_out_byte),
    .out_destination (out_destination),
    .out_last_of_run (out_last_of_run)
  );

endmodule

// File: rtl/sfd_regs.sv
// Configuration registers of the SBUS frame deframer behind an APB-style port.
`timescale 1ns / 1ps

module sfd_regs
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_OUTER_HEAD: cfg_nxt.outer_head = cfg_pwdata[7:0];
        REG_OUTER_TAIL: cfg_nxt.outer_tail = cfg_pwdata[7:0];
        REG_INNER_HEAD: cfg_nxt.inner_head = cfg_pwdata[7:0];
        REG_INNER_TAIL: cfg_nxt.inner_tail = cfg_pwdata[7:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_head <= OUTER_HEAD_RST;
      cfg_r.outer_tail <= OUTER_TAIL_RST;
      cfg_r.inner_head <= INNER_HEAD_RST;
      cfg_r.inner_tail <= INNER_TAIL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (cfg_paddr[3:2])
      REG_OUTER_HEAD: cfg_prdata = {24'd0, cfg_r.outer_head};
      REG_OUTER_TAIL: cfg_prdata = {24'd0, cfg_r.outer_tail};
      REG_INNER_HEAD: cfg_prdata = {24'd0, cfg_r.inner_head};
      REG_INNER_TAIL: cfg_prdata = {24'd0, cfg_r.inner_tail};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/sfd_ctrl.sv
// Parser and emit sequencer of the SBUS frame deframer.
`timescale 1ns / 1ps

module sfd_ctrl
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        accept;
  logic        hit_ok;
  logic        hit_fail;
  logic        advance;

  assign accept = in_valid && (state_r != ST_EMIT);

  // Verdict on the byte at the input
  always_comb begin
    hit_ok   = 1'b0;
    hit_fail = 1'b0;
    advance  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        advance  = st.match_outer_head;
        hit_fail = !st.match_outer_head;
      end
      ST_OUTER_HEAD: begin
        advance  = st.match_inner_head;
        hit_fail = !st.match_inner_head;
      end
      ST_INNER_HEAD: begin
        advance = st.payload_done;
      end
      ST_PAYLOAD: begin
        advance  = st.match_inner_tail;
        hit_fail = !st.match_inner_tail;
      end
      ST_INNER_TAIL: begin
        hit_ok   = st.match_outer_tail;
        hit_fail = !st.match_outer_tail;
      end
      ST_EMIT: begin
      end
      default: begin
        hit_fail = 1'b1;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_OUTER_HEAD, ST_INNER_HEAD, ST_PAYLOAD, ST_INNER_TAIL: begin
        if (accept) begin
          if (hit_ok || hit_fail) begin
            state_nxt = ST_EMIT;
          end else if (advance) begin
            case (state_r)
              ST_IDLE:       state_nxt = ST_OUTER_HEAD;
              ST_OUTER_HEAD: state_nxt = ST_INNER_HEAD;
              ST_INNER_HEAD: state_nxt = ST_PAYLOAD;
              ST_PAYLOAD:    state_nxt = ST_INNER_TAIL;
              default:       state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_EMIT: begin
        if (st.out_free && st.emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_stall       = 1'b0;
    cmd.wr         = 1'b0;
    cmd.start_ok   = 1'b0;
    cmd.start_fail = 1'b0;
    cmd.emit       = 1'b0;
    case (state_r)
      ST_EMIT: begin
        in_stall = 1'b1;
        cmd.emit = st.out_free;
      end
      default: begin
        cmd.wr         = accept;
        cmd.start_ok   = accept && hit_ok;
        cmd.start_fail = accept && hit_fail;
      end
    endcase
  end

endmodule

// File: rtl/sfd_dp.sv
// Frame store, counters, comparators and output register of the SBUS frame deframer.
`timescale 1ns / 1ps

module sfd_dp
  import sfd_pkg::*;
#(
  parameter int PAYLOAD_BYTES = SBUS_PAYLOAD_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  cfg_t       cfg,
  input  dp_cmd_t    cmd,
  output dp_status_t st,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_destination,
  output logic       out_last_of_run
);

  localparam int DEPTH     = PAYLOAD_BYTES + 4;
  localparam int INNER_LEN = PAYLOAD_BYTES + 2;
  localparam int IW        = $clog2(DEPTH);
  localparam int CW        = $clog2(DEPTH + 1);

  logic [7:0]    store_r [DEPTH];
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [IW-1:0] emit_idx_r;
  logic [IW-1:0] emit_idx_nxt;
  logic [IW-1:0] emit_end_r;
  logic [IW-1:0] emit_end_nxt;
  logic          emit_dest_r;
  logic          emit_dest_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic [7:0]    out_byte_r;
  logic          out_dest_r;
  logic          out_last_r;
  logic          store_full;
  logic [IW-1:0] fail_end;

  assign store_full = (count_r == CW'(DEPTH));
  assign fail_end   = store_full ? IW'(DEPTH - 1) : count_r[IW-1:0];

  // Byte store, written at the fill count
  always_ff @(posedge clk) begin
    if (cmd.wr && !store_full) begin
      store_r[count_r[IW-1:0]] <= in_byte;
    end
  end

  // Fill count: cleared whenever a run starts
  always_comb begin
    count_nxt = count_r;
    if (cmd.start_ok || cmd.start_fail) begin
      count_nxt = '0;
    end else if (cmd.wr && !store_full) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // Run bounds and read pointer
  always_comb begin
    emit_idx_nxt  = emit_idx_r;
    emit_end_nxt  = emit_end_r;
    emit_dest_nxt = emit_dest_r;
    if (cmd.start_ok) begin
      emit_idx_nxt  = IW'(1);
      emit_end_nxt  = IW'(INNER_LEN);
      emit_dest_nxt = DEST_SBUS;
    end else if (cmd.start_fail) begin
      emit_idx_nxt  = '0;
      emit_end_nxt  = fail_end;
      emit_dest_nxt = DEST_PASS;
    end else if (cmd.emit) begin
      emit_idx_nxt = emit_idx_r + 1'b1;
    end
  end

  // Output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    emit_idx_r  <= emit_idx_nxt;
    emit_end_r  <= emit_end_nxt;
    emit_dest_r <= emit_dest_nxt;
    if (cmd.emit) begin
      out_byte_r <= store_r[emit_idx_r];
      out_dest_r <= emit_dest_r;
      out_last_r <= (emit_idx_r == emit_end_r);
    end
  end

  // Status back to the controller
  assign st.match_outer_head = (in_byte == cfg.outer_head);
  assign st.match_outer_tail = (in_byte == cfg.outer_tail);
  assign st.match_inner_head = (in_byte == cfg.inner_head);
  assign st.match_inner_tail = (in_byte == cfg.inner_tail);
  assign st.payload_done     = ({1'b0, count_r} + 1'b1) >= (CW + 1)'(INNER_LEN);
  assign st.out_free         = !out_valid_r || !out_stall;
  assign st.emit_last        = (emit_idx_r == emit_end_r);

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_destination = out_dest_r;
  assign out_last_of_run = out_last_r;

endmodule

// File: tb/wrapped_sbus_frame_demux_core_tb.sv
// Self-checking testbench of the SBUS frame deframer: random framing, stalls and register settings.
`timescale 1ns / 1ps

module wrapped_sbus_frame_demux_core_tb;
  import sfd_pkg::*;

  localparam int PAYLOAD     = SBUS_PAYLOAD_BYTES_DEF;
  localparam int STORE_DEPTH = PAYLOAD + 4;  // outer head .. outer tail
  localparam int INNER_LEN   = PAYLOAD + 2;  // inner head .. inner tail
  localparam int IDLE_LIMIT  = 2000;         // cycles with no transfer at all
  localparam int LONG_HOLD   = 400;          // receiver hold-off in cycles
  localparam int SETTLE      = 40;           // quiet cycles before a register write
  localparam int PHASE_BYTES = 24;           // random bytes per register setting

  // One beat on the result channel
  typedef struct packed {
    logic [7:0] data;
    logic       dest;
    logic       last;
  } sbus_beat_t;

  // Frame parser mirror plus queue of beats still owed by the block
  class frame_scoreboard;
    logic [7:0]  frame_bytes [4];
    ctrl_state_t phase;
    int unsigned fill;
    logic [7:0]  store [STORE_DEPTH];
    sbus_beat_t  owed_q [$];
    int unsigned errors, in_beats, out_beats, good_frames, rejected_runs;

    function new();
      frame_bytes[REG_OUTER_HEAD] = OUTER_HEAD_RST;
      frame_bytes[REG_OUTER_TAIL] = OUTER_TAIL_RST;
      frame_bytes[REG_INNER_HEAD] = INNER_HEAD_RST;
      frame_bytes[REG_INNER_TAIL] = INNER_TAIL_RST;
      phase = ST_IDLE;
      fill = 0;
      errors = 0;
      in_beats = 0;
      out_beats = 0;
      good_frames = 0;
      rejected_runs = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      frame_bytes[idx] = val;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Queue a run of stored bytes, last flag on the final one
    function void queue_run(int unsigned first, int unsigned len, logic dest);
      sbus_beat_t beat;
      for (int unsigned k = 0; k < len; k++) begin
        beat.data = store[first + k];
        beat.dest = dest;
        beat.last = (k + 1 == len);
        owed_q.push_back(beat);
      end
    endfunction

    // Accepted input byte: advance the parser, queue any run it ends
    function void note_rx(logic [7:0] b);
      bit ok, fail;
      ok = 0;
      fail = 0;
      in_beats++;
      if (fill < STORE_DEPTH) begin
        store[fill] = b;
        fill++;
      end
      case (phase)
        ST_IDLE: begin
          if (b == frame_bytes[REG_OUTER_HEAD]) phase = ST_OUTER_HEAD;
          else fail = 1;
        end
        ST_OUTER_HEAD: begin
          if (b == frame_bytes[REG_INNER_HEAD]) phase = ST_INNER_HEAD;
          else fail = 1;
        end
        ST_INNER_HEAD: begin
          if (fill >= INNER_LEN) phase = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          if (b == frame_bytes[REG_INNER_TAIL]) phase = ST_INNER_TAIL;
          else fail = 1;
        end
        ST_INNER_TAIL: begin
          if (b == frame_bytes[REG_OUTER_TAIL]) ok = 1;
          else fail = 1;
        end
        default: fail = 1;
      endcase
      if (ok) begin
        queue_run(1, INNER_LEN, DEST_SBUS);
        good_frames++;
      end else if (fail) begin
        queue_run(0, fill, DEST_PASS);
        rejected_runs++;
      end
      if (ok || fail) begin
        phase = ST_IDLE;
        fill = 0;
      end
    endfunction

    // Accepted result beat: compare with the oldest owed beat
    function void check_beat(logic [7:0] data, logic dest, logic last);
      sbus_beat_t exp_beat;
      out_beats++;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected beat data=%02h dest=%0d last=%0d", $time, data, dest, last);
        errors++;
        return;
      end
      exp_beat = owed_q.pop_front();
      if (data !== exp_beat.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, exp_beat.data, data);
        errors++;
      end
      if (dest !== exp_beat.dest) begin
        $display("%0t: destination expected %0d actual %0d", $time, exp_beat.dest, dest);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $display("%0t: last_of_run expected %0d actual %0d", $time, exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_destination;
  logic        out_last_of_run;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_scoreboard sb;
  int unsigned     burst_left;
  int unsigned     tx_count;
  int unsigned     settings_used;
  bit              hold_req;

  wrapped_sbus_frame_demux_core #(
    .PAYLOAD_BYTES(PAYLOAD)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_out_byte   (out_out_byte),
    .out_destination(out_destination),
    .out_last_of_run(out_last_of_run),
    .cfg_psel       (cfg_psel),
    .cfg_penable    (cfg_penable),
    .cfg_pwrite     (cfg_pwrite),
    .cfg_paddr      (cfg_paddr),
    .cfg_pwdata     (cfg_pwdata),
    .cfg_prdata     (cfg_prdata),
    .cfg_pready     (cfg_pready)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Monitor: both channels sampled at the edge that accepts a beat
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (in_valid && !in_stall) sb.note_rx(in_rx_byte);
        if (out_valid && !out_stall) sb.check_beat(out_out_byte, out_destination, out_last_of_run);
      end
    end
  end

  // Receiver: stall mode redrawn at random from time to time; one long hold-off on request
  initial begin
    int unsigned mode, tick;
    out_stall = 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else begin
        if (tick % 64 == 0) mode = $urandom_range(0, 2);
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          default: out_stall <= ((tick % 8) < 3);
        endcase
      end
    end
  end

  // Watchdog: ends the run after too long without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_psel && cfg_penable && cfg_pready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: watchdog, no transfer for %0d cycles, %0d beats owed",
             $time, IDLE_LIMIT, sb.pending());
    $display("Test completed with failures");
    $finish;
  end

  // One input beat; the sender goes quiet for a while at the end of each burst
  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    tx_count++;
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
  endtask

  // Register write, then read back
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== val) begin
      $display("%0t: reg %0d readback expected %02h actual %02h", $time, idx, val, cfg_prdata[7:0]);
      sb.errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_framing(input logic [7:0] oh, input logic [7:0] ot,
                             input logic [7:0] ih, input logic [7:0] it);
    write_reg(REG_OUTER_HEAD, oh);
    write_reg(REG_OUTER_TAIL, ot);
    write_reg(REG_INNER_HEAD, ih);
    write_reg(REG_INNER_TAIL, it);
    settings_used++;
  endtask

  // Drain all owed beats, then let the parser settle before touching registers
  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Byte at a frame position under the current framing; payload is random
  function automatic logic [7:0] frame_byte(int pos);
    if (pos == 0) return sb.frame_bytes[REG_OUTER_HEAD];
    if (pos == 1) return sb.frame_bytes[REG_INNER_HEAD];
    if (pos == INNER_LEN) return sb.frame_bytes[REG_INNER_TAIL];
    if (pos == INNER_LEN + 1) return sb.frame_bytes[REG_OUTER_TAIL];
    return 8'($urandom);
  endfunction

  // Frame that breaks at position fail_at; fail_at >= STORE_DEPTH sends a good frame
  task automatic send_frame(input int fail_at);
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (i == fail_at) begin
        send_byte(frame_byte(i) ^ 8'($urandom_range(1, 255)));
        return;
      end
      send_byte(frame_byte(i));
    end
  endtask

  // Random mix of well-formed frames, broken frames and line noise
  task automatic random_phase(input int unsigned n, input bit pause_mid);
    int unsigned start, kind;
    bit paused;
    start = tx_count;
    paused = 0;
    while (tx_count - start < n) begin
      if (pause_mid && !paused && tx_count - start >= n / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        paused = 1;
      end
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        send_frame(STORE_DEPTH);
      end else if (kind < 8) begin
        case ($urandom_range(0, 3))
          0: send_frame(0);
          1: send_frame(1);
          2: send_frame(INNER_LEN);
          default: send_frame(INNER_LEN + 1);
        endcase
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    logic [7:0] pick [4];
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_req    = 0;
    tx_count    = 0;
    settings_used = 0;
    burst_left  = 20;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset framing, directed: idle rejects, bad inner head, good frame
    set_framing(OUTER_HEAD_RST, OUTER_TAIL_RST, INNER_HEAD_RST, INNER_TAIL_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(OUTER_HEAD_RST);
    send_byte(OUTER_HEAD_RST);
    send_byte(OUTER_HEAD_RST);
    send_byte(INNER_HEAD_RST);
    for (int i = 0; i < PAYLOAD; i++) send_byte((i % 2) ? 8'hFF : 8'h00);
    send_byte(INNER_TAIL_RST);
    send_byte(OUTER_TAIL_RST);
    random_phase(PHASE_BYTES, 0);

    // All framing bytes zero; receiver holds off long enough to back up the input
    quiesce();
    set_framing(8'h00, 8'h00, 8'h00, 8'h00);
    hold_req = 1;
    random_phase(PHASE_BYTES, 0);

    // All framing bytes 0xFF; sender drains the block halfway through
    quiesce();
    set_framing(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    random_phase(PHASE_BYTES, 1);

    // Random framing bytes
    quiesce();
    set_framing(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_phase(PHASE_BYTES, 0);

    // Mix of extremes and random values, often repeated across registers
    quiesce();
    for (int r = 0; r < 4; r++) begin
      case ($urandom_range(0, 2))
        0: pick[r] = 8'h00;
        1: pick[r] = 8'hFF;
        default: pick[r] = 8'($urandom);
      endcase
    end
    set_framing(pick[0], pick[1], pick[2], pick[3]);
    random_phase(PHASE_BYTES, 0);

    // Drain and finish
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * STORE_DEPTH) @(posedge clk);
    $display("Covered %0d input bytes and %0d result beats: %0d SBUS frames, %0d rejected runs,",
             sb.in_beats, sb.out_beats, sb.good_frames, sb.rejected_runs);
    $display("under %0d framing settings including all-zero and all-ones.", settings_used);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
